/* hw/rtl/ptd_pkg.sv */
package ptd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 16;
    localparam int THRESH_BITS = 15;
    localparam int ORD_BITS    = 16;
    localparam int CMP_BITS    =
        ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1024);

    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_TROUGH = 1'b1;

    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_RISING    = 2'd1,
        MODE_FALLING   = 2'd2
    } ptd_mode_t;

    typedef struct packed {
        ptd_mode_t               mode;
        logic                    started;
        logic signed [SAMPLE_BITS-1:0] max_level;
        logic [INDEX_BITS-1:0]   max_position;
        logic signed [SAMPLE_BITS-1:0] min_level;
        logic [INDEX_BITS-1:0]   min_position;
        logic [INDEX_BITS-1:0]   sample_count;
        logic [ORD_BITS-1:0]     peak_total;
        logic [ORD_BITS-1:0]     trough_total;
    } ptd_state_t;

    typedef struct packed {
        logic                          kind;
        logic [INDEX_BITS-1:0]         position;
        logic signed [SAMPLE_BITS-1:0] level;
        logic [ORD_BITS-1:0]           ordinal;
    } ptd_result_t;

    localparam ptd_state_t STATE_CLEAR = '{
        mode: MODE_UNDECIDED,
        started: 1'b0,
        max_level: '0,
        max_position: '0,
        min_level: '0,
        min_position: '0,
        sample_count: '0,
        peak_total: '0,
        trough_total: '0
    };

endpackage

/* hw/rtl/ptd_decide.sv */
module ptd_decide
    import ptd_pkg::*;
(
    input  ptd_state_t                    state,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic [THRESH_BITS-1:0]        threshold,
    output ptd_state_t                    state_next,
    output logic                          res_valid,
    output ptd_result_t                   result
);

    logic signed [CMP_BITS-1:0] x_w;
    logic signed [CMP_BITS-1:0] mx_w;
    logic signed [CMP_BITS-1:0] mn_w;
    logic signed [CMP_BITS-1:0] e_w;
    logic signed [SAMPLE_BITS-1:0] mx;
    logic signed [SAMPLE_BITS-1:0] mn;
    logic [INDEX_BITS-1:0] mxp;
    logic [INDEX_BITS-1:0] mnp;
    logic [INDEX_BITS-1:0] idx;
    logic fall_ok;
    logic rise_ok;
    logic max_le;
    logic min_ge;
    ptd_state_t s;

    assign idx = state.sample_count;
    assign mx  = state.started ? state.max_level    : sample;
    assign mn  = state.started ? state.min_level    : sample;
    assign mxp = state.started ? state.max_position : idx;
    assign mnp = state.started ? state.min_position : idx;

    assign x_w  = CMP_BITS'(sample);
    assign mx_w = CMP_BITS'(mx);
    assign mn_w = CMP_BITS'(mn);
    assign e_w  = $signed({{(CMP_BITS-THRESH_BITS){1'b0}}, threshold});

    assign fall_ok = (mx_w - x_w) >= e_w;
    assign rise_ok = (x_w - mn_w) >= e_w;
    assign max_le  = mx <= sample;
    assign min_ge  = sample <= mn;

    always_comb begin
        s              = state;
        s.started      = 1'b1;
        s.max_level    = mx;
        s.max_position = mxp;
        s.min_level    = mn;
        s.min_position = mnp;
        res_valid      = 1'b0;
        result         = '{kind: KIND_PEAK, position: mxp, level: mx,
                           ordinal: state.peak_total};
        case (state.mode)
            MODE_RISING: begin
                if (max_le) begin
                    s.max_level    = sample;
                    s.max_position = idx;
                end else if (fall_ok) begin
                    res_valid      = 1'b1;
                    if (state.peak_total != '1) begin
                        s.peak_total = state.peak_total + 1'b1;
                    end
                    s.min_level    = sample;
                    s.min_position = idx;
                    s.mode         = MODE_FALLING;
                end
            end
            MODE_FALLING: begin
                result = '{kind: KIND_TROUGH, position: mnp, level: mn,
                           ordinal: state.trough_total};
                if (min_ge) begin
                    s.min_level    = sample;
                    s.min_position = idx;
                end else if (rise_ok) begin
                    res_valid      = 1'b1;
                    if (state.trough_total != '1) begin
                        s.trough_total = state.trough_total + 1'b1;
                    end
                    s.max_level    = sample;
                    s.max_position = idx;
                    s.mode         = MODE_RISING;
                end
            end
            default: begin
                if (fall_ok) begin
                    s.mode = MODE_FALLING;
                end else if (rise_ok) begin
                    s.mode = MODE_RISING;
                end
                if (max_le) begin
                    s.max_level    = sample;
                    s.max_position = idx;
                end else if (min_ge) begin
                    s.min_level    = sample;
                    s.min_position = idx;
                end
            end
        endcase
        s.sample_count = idx + 1'b1;
        state_next = last ? STATE_CLEAR : s;
    end

endmodule

/* hw/rtl/ptd_out_stage.sv */
module ptd_out_stage
    import ptd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  ptd_result_t result,
    input  logic        m_ready,
    output logic        busy,
    output logic        m_valid,
    output ptd_result_t m_result
);

    logic        valid_reg;
    logic        valid_next;
    ptd_result_t result_reg;

    assign busy       = valid_reg && !m_ready;
    assign valid_next = load || busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

/* hw/rtl/peak_trough_detector.sv */
// Hysteresis peak and trough detector. Takes one signed sample per cycle and
// reports each confirmed extremum as one result (kind, position, level,
// ordinal). A request is held in an input register and decided there against
// the tracked maximum, minimum and mode; a result is on m_ in the cycle after
// the decision. Throughput is one sample per cycle; a sample that confirms
// an extremum waits in the input register while the output register still
// holds an untaken result. A sample flagged last is processed normally and
// then clears mode, extrema, index and counts. threshold resets to 1024; the
// user must write it only while no sample is in flight (not enforced here).
module peak_trough_detector
    import ptd_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          threshold_wr_en,
    input  logic [THRESH_BITS-1:0]        threshold_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [INDEX_BITS-1:0]         m_position,
    output logic signed [SAMPLE_BITS-1:0] m_level,
    output logic [ORD_BITS-1:0]           m_ordinal
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_last_reg;
    logic [THRESH_BITS-1:0]        threshold_reg;
    ptd_state_t                    state_reg;
    ptd_state_t                    state_next;
    logic                          res_valid;
    ptd_result_t                   result;
    ptd_result_t                   m_result;
    logic                          out_busy;
    logic                          advance;
    logic                          load;

    ptd_decide u_decide (
        .state      (state_reg),
        .sample     (in_sample_reg),
        .last       (in_last_reg),
        .threshold  (threshold_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .result     (result)
    );

    // advance unless a result must go into a held output register
    assign advance       = in_valid_reg && !(res_valid && out_busy);
    assign load          = advance && res_valid;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            threshold_reg <= THRESH_RESET;
            state_reg     <= STATE_CLEAR;
        end else begin
            in_valid_reg <= in_valid_next;
            if (threshold_wr_en) begin
                threshold_reg <= threshold_wr_data;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_last;
        end
    end

    ptd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .m_ready  (m_ready),
        .busy     (out_busy),
        .m_valid  (m_valid),
        .m_result (m_result)
    );

    assign m_kind     = m_result.kind;
    assign m_position = m_result.position;
    assign m_level    = m_result.level;
    assign m_ordinal  = m_result.ordinal;

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> state_reg == STATE_CLEAR)
        else $error("state not cleared after last sample");

    a_result_needs_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> state_reg.mode != MODE_UNDECIDED)
        else $error("result issued while undecided");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !load)
        else $error("held result overwritten");

    a_unstarted_undecided: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.started |-> state_reg.mode == MODE_UNDECIDED
            && state_reg.sample_count == '0)
        else $error("record state active before first sample");

    a_result_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("confirmed extremum did not reach output");

endmodule
